// File: hw/rtl/pscl_pkg.sv
// Shared types, codes and constants for the page slot cache.
// Used by the top level; depends on nothing else.
package pscl_pkg;

   localparam int MAX_SLOTS_DEF = 256;
   localparam int ACTIVE_RESET  = 12;
   localparam int CSR_W         = 9;
   localparam int MODE_W        = 2;
   localparam int COORD_W       = 16;
   localparam int STAMP_W       = 32;
   localparam int STATUS_W      = 2;
   localparam int SLOT_OUT_W    = 8;
   localparam int BIND_W        = 9;
   localparam int BIND_MAX      = 511;

   typedef enum logic [MODE_W-1:0] {
      MODE_NEW_FRAME = 2'd0,
      MODE_ACQUIRE   = 2'd1,
      MODE_LOOKUP    = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_HIT   = 2'd0,
      STATUS_BOUND = 2'd1,
      STATUS_NONE  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SCAN,
      STATE_FINISH
   } state_type;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// File: hw/rtl/pscl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; depends on nothing else.
module pscl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/page_slot_cache_lru_top.sv
// Top level of the fully associative page slot cache with LRU replacement.
// Depends on pscl_pkg and pscl_ram.
//
// A new frame transaction, or one with the unused mode code, returns its result in the cycle
// after start and leaves busy low. An acquire or lookup transaction scans the active slots
// through the single read port of the slot RAM, one slot per cycle, with busy high until
// the result strobe. Each result is on the rsp_ ports for exactly one cycle, marked by
// rsp_strobe, and the receiver cannot stall it. Configuration writes are always ready and
// belong in idle time.
module page_slot_cache_lru_top #(
   parameter int MAX_SLOTS = pscl_pkg::MAX_SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [pscl_pkg::MODE_W-1:0]    req_mode,
   input  logic [pscl_pkg::COORD_W-1:0]   req_page_col,
   input  logic [pscl_pkg::COORD_W-1:0]   req_page_row,
   output logic                           rsp_strobe,
   output logic [pscl_pkg::STATUS_W-1:0]  rsp_status,
   output logic [pscl_pkg::SLOT_OUT_W-1:0] rsp_slot_index,
   output logic [pscl_pkg::BIND_W-1:0]    rsp_binds_in_frame,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pscl_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int IDX_W = $clog2(MAX_SLOTS);
   localparam int CNT_W = $clog2(MAX_SLOTS + 1);

   function automatic logic [CNT_W-1:0] clamp_count(input logic [pscl_pkg::CSR_W-1:0] v);
      logic [CNT_W-1:0] n;
      if (v == '0) begin
         n = CNT_W'(1);
      end else if (32'(v) > 32'(MAX_SLOTS)) begin
         n = CNT_W'(MAX_SLOTS);
      end else begin
         n = CNT_W'(v);
      end
      return n;
   endfunction

   pscl_pkg::state_type           state_ff, state_in;
   logic [CNT_W-1:0]              live_ff, live_in;
   logic [MAX_SLOTS-1:0]          valid_ff, valid_in;
   logic [pscl_pkg::STAMP_W-1:0]  frame_ff, frame_in;
   logic [pscl_pkg::BIND_W-1:0]   bind_ff, bind_in;

   pscl_pkg::mode_type            mode_ff, mode_in;
   logic [pscl_pkg::COORD_W-1:0]  col_ff, col_in;
   logic [pscl_pkg::COORD_W-1:0]  row_ff, row_in;

   logic [IDX_W-1:0]              addr_ff, addr_in;
   logic                          issue_ff, issue_in;
   logic                          chk_ff, chk_in;
   logic [IDX_W-1:0]              chk_idx_ff, chk_idx_in;
   logic                          chk_vbit_ff, chk_vbit_in;
   logic                          last_ff, last_in;

   logic                          hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]              hit_idx_ff, hit_idx_in;
   logic                          empty_found_ff, empty_found_in;
   logic [IDX_W-1:0]              empty_idx_ff, empty_idx_in;
   logic                          best_found_ff, best_found_in;
   logic [IDX_W-1:0]              best_idx_ff, best_idx_in;
   logic [pscl_pkg::STAMP_W-1:0]  best_stamp_ff, best_stamp_in;

   logic                          rsp_strobe_ff, rsp_strobe_in;
   pscl_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]              rsp_slot_ff, rsp_slot_in;

   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   pscl_pkg::entry_type           wr_entry;
   pscl_pkg::entry_type           rd_entry;
   logic [pscl_pkg::ENTRY_W-1:0]  rd_data;
   logic [IDX_W-1:0]              last_idx;
   logic                          accept;
   logic                          match;
   logic [CNT_W-1:0]              cfg_count;

   pscl_ram #(
      .WIDTH(pscl_pkg::ENTRY_W),
      .DEPTH(MAX_SLOTS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_en  (issue_ff),
      .rd_addr(addr_ff),
      .rd_data(rd_data)
   );

   assign rd_entry  = pscl_pkg::entry_type'(rd_data);
   assign last_idx  = IDX_W'(live_ff - CNT_W'(1));
   assign busy      = (state_ff != pscl_pkg::STATE_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign cfg_count = clamp_count(csr_wdata);
   assign match     = chk_vbit_ff && (rd_entry.col == col_ff) && (rd_entry.row == row_ff);

   assign wr_entry.col   = col_ff;
   assign wr_entry.row   = row_ff;
   assign wr_entry.stamp = frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pscl_pkg::STATE_IDLE;
         live_ff       <= clamp_count(pscl_pkg::CSR_W'(pscl_pkg::ACTIVE_RESET));
         valid_ff      <= '0;
         frame_ff      <= '0;
         bind_ff       <= '0;
         issue_ff      <= 1'b0;
         chk_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         live_ff       <= live_in;
         valid_ff      <= valid_in;
         frame_ff      <= frame_in;
         bind_ff       <= bind_in;
         issue_ff      <= issue_in;
         chk_ff        <= chk_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      mode_ff        <= mode_in;
      col_ff         <= col_in;
      row_ff         <= row_in;
      addr_ff        <= addr_in;
      chk_idx_ff     <= chk_idx_in;
      chk_vbit_ff    <= chk_vbit_in;
      last_ff        <= last_in;
      hit_found_ff   <= hit_found_in;
      hit_idx_ff     <= hit_idx_in;
      empty_found_ff <= empty_found_in;
      empty_idx_ff   <= empty_idx_in;
      best_found_ff  <= best_found_in;
      best_idx_ff    <= best_idx_in;
      best_stamp_ff  <= best_stamp_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

   always_comb begin
      state_in       = state_ff;
      live_in        = live_ff;
      valid_in       = valid_ff;
      frame_in       = frame_ff;
      bind_in        = bind_ff;
      mode_in        = mode_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      addr_in        = addr_ff;
      issue_in       = issue_ff;
      chk_in         = 1'b0;
      chk_idx_in     = chk_idx_ff;
      chk_vbit_in    = chk_vbit_ff;
      last_in        = last_ff;
      hit_found_in   = hit_found_ff;
      hit_idx_in     = hit_idx_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      best_found_in  = best_found_ff;
      best_idx_in    = best_idx_ff;
      best_stamp_in  = best_stamp_ff;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      wr_en          = 1'b0;
      wr_addr        = hit_idx_ff;

      if (csr_valid && csr_ready) begin
         live_in = cfg_count;
         for (int i = 0; i < MAX_SLOTS; i++) begin
            if (32'(i) >= 32'(cfg_count)) begin
               valid_in[i] = 1'b0;
            end
         end
      end

      case (state_ff)
         pscl_pkg::STATE_IDLE: begin
            if (accept) begin
               mode_in        = pscl_pkg::mode_type'(req_mode);
               col_in         = req_page_col;
               row_in         = req_page_row;
               addr_in        = '0;
               hit_found_in   = 1'b0;
               empty_found_in = 1'b0;
               best_found_in  = 1'b0;
               case (pscl_pkg::mode_type'(req_mode))
                  pscl_pkg::MODE_NEW_FRAME: begin
                     frame_in      = frame_ff + pscl_pkg::STAMP_W'(1);
                     bind_in       = '0;
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = pscl_pkg::STATUS_HIT;
                     rsp_slot_in   = '0;
                  end
                  pscl_pkg::MODE_ACQUIRE, pscl_pkg::MODE_LOOKUP: begin
                     issue_in = 1'b1;
                     state_in = pscl_pkg::STATE_SCAN;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = pscl_pkg::STATUS_NONE;
                     rsp_slot_in   = '0;
                  end
               endcase
            end
         end
         pscl_pkg::STATE_SCAN: begin
            if (issue_ff) begin
               chk_in      = 1'b1;
               chk_idx_in  = addr_ff;
               chk_vbit_in = valid_ff[addr_ff];
               last_in     = (addr_ff == last_idx);
               if (addr_ff == last_idx) begin
                  issue_in = 1'b0;
               end else begin
                  addr_in = addr_ff + IDX_W'(1);
               end
            end
            if (chk_ff) begin
               if (match && !hit_found_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = chk_idx_ff;
               end
               if (!chk_vbit_ff) begin
                  if (!empty_found_ff) begin
                     empty_found_in = 1'b1;
                     empty_idx_in   = chk_idx_ff;
                  end
               end else if ((rd_entry.stamp != frame_ff) &&
                            (!best_found_ff || (rd_entry.stamp < best_stamp_ff))) begin
                  best_found_in = 1'b1;
                  best_idx_in   = chk_idx_ff;
                  best_stamp_in = rd_entry.stamp;
               end
               if (last_ff) begin
                  state_in = pscl_pkg::STATE_FINISH;
               end
            end
         end
         pscl_pkg::STATE_FINISH: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = pscl_pkg::STATUS_NONE;
            rsp_slot_in   = '0;
            state_in      = pscl_pkg::STATE_IDLE;
            if (hit_found_ff) begin
               rsp_status_in = pscl_pkg::STATUS_HIT;
               rsp_slot_in   = hit_idx_ff;
               if (mode_ff == pscl_pkg::MODE_ACQUIRE) begin
                  wr_en   = 1'b1;
                  wr_addr = hit_idx_ff;
               end
            end else if ((mode_ff == pscl_pkg::MODE_ACQUIRE) &&
                         (empty_found_ff || best_found_ff)) begin
               wr_en   = 1'b1;
               wr_addr = empty_found_ff ? empty_idx_ff : best_idx_ff;
               valid_in[wr_addr] = 1'b1;
               if (bind_ff != pscl_pkg::BIND_W'(pscl_pkg::BIND_MAX)) begin
                  bind_in = bind_ff + pscl_pkg::BIND_W'(1);
               end
               rsp_status_in = pscl_pkg::STATUS_BOUND;
               rsp_slot_in   = wr_addr;
            end
         end
         default: begin
            state_in = pscl_pkg::STATE_IDLE;
         end
      endcase
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slot_index     = pscl_pkg::SLOT_OUT_W'(rsp_slot_ff);
   assign rsp_binds_in_frame = bind_ff;

endmodule
